// File: hw/rtl/iso8601_utc_timestamp_parser_macros.svh
// Assertion macros shared by the timestamp parser RTL.
`ifndef ISO8601_UTC_TIMESTAMP_PARSER_MACROS_SVH
`define ISO8601_UTC_TIMESTAMP_PARSER_MACROS_SVH
`ifndef SYNTH
`define IUTP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("iutp: assertion failed");
`define IUTP_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("iutp: forbidden condition seen");
`else
`define IUTP_ASSERT(label, prop)
`define IUTP_ASSERT_NEVER(label, cond)
`endif
`endif

// File: hw/rtl/iutp_pkg.sv
// Types, constants and tables shared by the timestamp parser modules.
`timescale 1ns / 1ps
`default_nettype none
package iutp_pkg;

	localparam int MID_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF = 8;
	localparam int EPOCH_W = 36;

	typedef enum logic [4:0] {
		PH_YEAR    = 5'd0,
		PH_DASH1   = 5'd1,
		PH_MONTH   = 5'd2,
		PH_DASH2   = 5'd3,
		PH_DAY     = 5'd4,
		PH_SEP     = 5'd5,
		PH_HOUR    = 5'd6,
		PH_COLON1  = 5'd7,
		PH_MINUTE  = 5'd8,
		PH_COLON2  = 5'd9,
		PH_SECOND  = 5'd10,
		PH_AFTER   = 5'd11,
		PH_FRAC    = 5'd12,
		PH_ZHOUR   = 5'd13,
		PH_ZCOLON  = 5'd14,
		PH_ZMINUTE = 5'd15,
		PH_DONE    = 5'd16
	} phase_t;

	typedef enum logic [1:0] {
		ZS_NONE  = 2'd0,
		ZS_PLUS  = 2'd1,
		ZS_MINUS = 2'd2
	} zone_sign_t;

	typedef struct packed {
		logic       ok;
		logic [13:0] year;
		logic [6:0] month;
		logic [6:0] day;
		logic [6:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
		logic [6:0] zone_hours;
		logic [6:0] zone_minutes;
		zone_sign_t zone_sign;
	} record_t;

	typedef struct packed {
		logic                      valid_res;
		logic signed [EPOCH_W-1:0] epoch_seconds;
	} result_t;

	// Days from March 1 to the first day of the month, month counted from January as 0.
	function automatic logic [8:0] month_start_day(input logic [3:0] month);
		logic [8:0] days;
		unique case (month)
			4'd0:    days = 9'd306;
			4'd1:    days = 9'd337;
			4'd2:    days = 9'd0;
			4'd3:    days = 9'd31;
			4'd4:    days = 9'd61;
			4'd5:    days = 9'd92;
			4'd6:    days = 9'd122;
			4'd7:    days = 9'd153;
			4'd8:    days = 9'd184;
			4'd9:    days = 9'd214;
			4'd10:   days = 9'd245;
			4'd11:   days = 9'd275;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/iutp_queue.sv
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps
`default_nettype none
module iutp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire logic [WIDTH-1:0]             wdata,
	output logic                              full,
	input  wire logic                         pop,
	output logic [WIDTH-1:0]                  rdata,
	output logic                              empty,
	output logic [$clog2(DEPTH+1)-1:0]        count
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/iutp_front.sv
// Character parser that turns one timestamp string into a field record.
`timescale 1ns / 1ps
`default_nettype none
module iutp_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       char_code,
	input  wire logic             last_char,
	output logic                  rec_push,
	output iutp_pkg::record_t     rec
);

	localparam logic [7:0] ChDash  = 8'h2D;
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChDot   = 8'h2E;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChUpT   = 8'h54;
	localparam logic [7:0] ChLowT  = 8'h74;
	localparam logic [7:0] ChSpace = 8'h20;

	iutp_pkg::phase_t     phase_q, phase_d, phase_inc;
	logic [2:0]           count_q, count_d, count_inc;
	logic [13:0]          year_q, year_d;
	logic [6:0]           month_q, month_d, day_q, day_d;
	logic [6:0]           hour_q, hour_d, minute_q, minute_d, second_q, second_d;
	logic [6:0]           zh_q, zh_d, zm_q, zm_d;
	iutp_pkg::zone_sign_t sign_q, sign_d;
	logic                 err_q, err_d;

	logic        is_digit;
	logic [3:0]  digit;
	logic [13:0] field_cur;
	logic [13:0] field_acc;
	logic [2:0]  field_len;
	logic        field_full;
	logic        is_zone_sign;

	assign is_digit     = (char_code >= 8'h30) && (char_code <= 8'h39);
	assign digit        = char_code[3:0];
	assign field_len    = (phase_q == iutp_pkg::PH_YEAR) ? 3'd4 : 3'd2;
	assign count_inc    = count_q + 3'd1;
	assign field_full   = (count_inc == field_len);
	assign phase_inc    = iutp_pkg::phase_t'(phase_q + 5'd1);
	assign is_zone_sign = (char_code == ChPlus) || (char_code == ChMinus);
	assign field_acc    = (count_q == '0) ? {10'd0, digit} :
		((field_cur << 3) + (field_cur << 1) + {10'd0, digit});

	always_comb begin
		unique case (phase_q)
			iutp_pkg::PH_YEAR:    field_cur = year_q;
			iutp_pkg::PH_MONTH:   field_cur = {7'd0, month_q};
			iutp_pkg::PH_DAY:     field_cur = {7'd0, day_q};
			iutp_pkg::PH_HOUR:    field_cur = {7'd0, hour_q};
			iutp_pkg::PH_MINUTE:  field_cur = {7'd0, minute_q};
			iutp_pkg::PH_SECOND:  field_cur = {7'd0, second_q};
			iutp_pkg::PH_ZHOUR:   field_cur = {7'd0, zh_q};
			iutp_pkg::PH_ZMINUTE: field_cur = {7'd0, zm_q};
			default:              field_cur = '0;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		zh_d     = zh_q;
		zm_d     = zm_q;
		sign_d   = sign_q;
		err_d    = err_q;
		if (!err_q) begin
			unique case (phase_q) inside
				iutp_pkg::PH_YEAR, iutp_pkg::PH_MONTH, iutp_pkg::PH_DAY,
				iutp_pkg::PH_HOUR, iutp_pkg::PH_MINUTE, iutp_pkg::PH_SECOND,
				iutp_pkg::PH_ZHOUR, iutp_pkg::PH_ZMINUTE: begin
					if (!is_digit) begin
						err_d = 1'b1;
					end else begin
						count_d = field_full ? 3'd0 : count_inc;
						if (field_full) begin
							phase_d = phase_inc;
						end
						if (phase_q == iutp_pkg::PH_YEAR)    year_d   = field_acc;
						if (phase_q == iutp_pkg::PH_MONTH)   month_d  = field_acc[6:0];
						if (phase_q == iutp_pkg::PH_DAY)     day_d    = field_acc[6:0];
						if (phase_q == iutp_pkg::PH_HOUR)    hour_d   = field_acc[6:0];
						if (phase_q == iutp_pkg::PH_MINUTE)  minute_d = field_acc[6:0];
						if (phase_q == iutp_pkg::PH_SECOND)  second_d = field_acc[6:0];
						if (phase_q == iutp_pkg::PH_ZHOUR)   zh_d     = field_acc[6:0];
						if (phase_q == iutp_pkg::PH_ZMINUTE) zm_d     = field_acc[6:0];
					end
				end
				iutp_pkg::PH_DASH1, iutp_pkg::PH_DASH2: begin
					if (char_code == ChDash) begin
						phase_d = phase_inc;
					end else begin
						err_d = 1'b1;
					end
				end
				iutp_pkg::PH_SEP: begin
					if ((char_code == ChUpT) || (char_code == ChLowT) || (char_code == ChSpace)) begin
						phase_d = phase_inc;
					end else begin
						err_d = 1'b1;
					end
				end
				iutp_pkg::PH_COLON1, iutp_pkg::PH_COLON2, iutp_pkg::PH_ZCOLON: begin
					if (char_code == ChColon) begin
						phase_d = phase_inc;
					end else begin
						err_d = 1'b1;
					end
				end
				iutp_pkg::PH_AFTER, iutp_pkg::PH_FRAC: begin
					if ((phase_q == iutp_pkg::PH_AFTER) && (char_code == ChDot)) begin
						phase_d = iutp_pkg::PH_FRAC;
					end else if ((phase_q == iutp_pkg::PH_FRAC) && is_digit) begin
						phase_d = iutp_pkg::PH_FRAC;
					end else if (is_zone_sign) begin
						sign_d  = (char_code == ChPlus) ? iutp_pkg::ZS_PLUS : iutp_pkg::ZS_MINUS;
						phase_d = iutp_pkg::PH_ZHOUR;
					end else begin
						phase_d = iutp_pkg::PH_DONE;
					end
				end
				iutp_pkg::PH_DONE: begin
					phase_d = iutp_pkg::PH_DONE;
				end
				default: begin
					err_d = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		rec_push         = accept && last_char;
		rec.ok           = !err_d && ((phase_d == iutp_pkg::PH_AFTER) ||
			(phase_d == iutp_pkg::PH_FRAC) || (phase_d == iutp_pkg::PH_DONE));
		rec.year         = year_d;
		rec.month        = month_d;
		rec.day          = day_d;
		rec.hour         = hour_d;
		rec.minute       = minute_d;
		rec.second       = second_d;
		rec.zone_hours   = zh_d;
		rec.zone_minutes = zm_d;
		rec.zone_sign    = sign_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= iutp_pkg::PH_YEAR;
			count_q  <= '0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			zh_q     <= '0;
			zm_q     <= '0;
			sign_q   <= iutp_pkg::ZS_NONE;
			err_q    <= 1'b0;
		end else if (accept && last_char) begin
			phase_q  <= iutp_pkg::PH_YEAR;
			count_q  <= '0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			zh_q     <= '0;
			zm_q     <= '0;
			sign_q   <= iutp_pkg::ZS_NONE;
			err_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			year_q   <= year_d;
			month_q  <= month_d;
			day_q    <= day_d;
			hour_q   <= hour_d;
			minute_q <= minute_d;
			second_q <= second_d;
			zh_q     <= zh_d;
			zm_q     <= zm_d;
			sign_q   <= sign_d;
			err_q    <= err_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/iutp_back.sv
// Five-stage converter from a field record to Unix seconds.
`timescale 1ns / 1ps
`default_nettype none
module iutp_back #(
	parameter int OUT_DEPTH = iutp_pkg::OUT_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           rec_empty,
	input  wire iutp_pkg::record_t              rec,
	output logic                                rec_pop,
	input  wire logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                                res_push,
	output iutp_pkg::result_t                   res
);

	localparam int NumStages = 5;
	localparam int SumW  = $clog2(OUT_DEPTH + NumStages + 2);
	localparam int DaysW = 23;
	localparam int TimeW = 40;
	localparam logic [DaysW-1:0] DaysBias = DaysW'(865566);
	localparam logic signed [17:0] SecsPerDay = 18'sd86400;
	localparam logic signed [TimeW-1:0] MaxSecs = 40'sd32535215999;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [SumW-1:0] inflight;

	// Stage 1: month carry into the year, shifted year for the day count.
	logic [6:0]  mon_m1;
	logic [12:0] mon_prod;
	logic [3:0]  mon_q;
	logic [6:0]  mon_rem;
	logic [14:0] yr;
	logic [3:0]  m_c;
	logic [14:0] yp_c;

	logic [13:0] yp_s1;
	logic [3:0]  m_s1;
	logic [6:0]  day_s1, hour_s1, minute_s1, second_s1, zh_s1, zm_s1;
	iutp_pkg::zone_sign_t sign_s1;
	logic ok_s1;

	assign mon_m1   = rec.month - 7'd1;
	assign mon_prod = 13'(mon_m1) * 13'd43;
	assign mon_q    = mon_prod[12:9];
	assign mon_rem  = mon_m1 - ({3'd0, mon_q} << 3) - ({3'd0, mon_q} << 2);
	assign yr       = (rec.month == '0) ? (15'(rec.year) - 15'd1) : (15'(rec.year) + 15'(mon_q));
	assign m_c      = (rec.month == '0) ? 4'd11 : mon_rem[3:0];
	assign yp_c     = yr - 15'(m_c < 4'd2) + 15'd400;

	// Stage 2: century count, month start day, time of day and zone offset.
	logic [11:0] quad_s1;
	logic [23:0] cent_prod;
	logic [18:0] sod_c, off_c;

	logic [13:0] yp_s2;
	logic [6:0]  cent_s2;
	logic [8:0]  doy_s2;
	logic [6:0]  day_s2;
	logic [18:0] sod_s2, off_s2;
	iutp_pkg::zone_sign_t sign_s2;
	logic ok_s2;

	assign quad_s1   = yp_s1[13:2];
	assign cent_prod = 24'(quad_s1) * 24'd2622;
	assign sod_c     = 19'(hour_s1) * 19'd3600 + 19'(minute_s1) * 19'd60 + 19'(second_s1);
	assign off_c     = 19'(zh_s1) * 19'd3600 + 19'(zm_s1) * 19'd60;

	// Stage 3: days since the epoch.
	logic [DaysW-1:0] days_c;
	logic signed [DaysW-1:0] days_s3;
	logic [18:0] sod_s3, off_s3;
	iutp_pkg::zone_sign_t sign_s3;
	logic ok_s3;

	assign days_c = DaysW'(yp_s2) * DaysW'(365) + DaysW'(yp_s2[13:2]) - DaysW'(cent_s2)
		+ DaysW'(cent_s2[6:2]) + DaysW'(doy_s2) + DaysW'(day_s2) - DaysBias;

	// Stage 4: seconds before the zone offset.
	logic signed [TimeW-1:0] day_secs;
	logic signed [TimeW-1:0] t_s4;
	logic [18:0] off_s4;
	iutp_pkg::zone_sign_t sign_s4;
	logic ok_s4;

	assign day_secs = days_s3 * SecsPerDay;

	// Stage 5: range check and zone correction.
	logic signed [TimeW-1:0] off_ext;
	logic signed [TimeW-1:0] secs_c;
	logic in_range;
	logic good_c;

	assign off_ext  = $signed(TimeW'(off_s4));
	assign in_range = !t_s4[TimeW-1] && (t_s4 <= MaxSecs);
	assign good_c   = ok_s4 && in_range;

	always_comb begin
		unique case (sign_s4)
			iutp_pkg::ZS_PLUS:  secs_c = t_s4 - off_ext;
			iutp_pkg::ZS_MINUS: secs_c = t_s4 + off_ext;
			default:            secs_c = t_s4;
		endcase
	end

	assign inflight = SumW'(out_count) + SumW'(v_s1) + SumW'(v_s2) + SumW'(v_s3)
		+ SumW'(v_s4) + SumW'(v_s5);
	assign rec_pop  = !rec_empty && (inflight < SumW'(OUT_DEPTH));
	assign res_push = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= rec_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		yp_s1     <= yp_c[13:0];
		m_s1      <= m_c;
		day_s1    <= rec.day;
		hour_s1   <= rec.hour;
		minute_s1 <= rec.minute;
		second_s1 <= rec.second;
		zh_s1     <= rec.zone_hours;
		zm_s1     <= rec.zone_minutes;
		sign_s1   <= rec.zone_sign;
		ok_s1     <= rec.ok;

		yp_s2   <= yp_s1;
		cent_s2 <= cent_prod[22:16];
		doy_s2  <= iutp_pkg::month_start_day(m_s1);
		day_s2  <= day_s1;
		sod_s2  <= sod_c;
		off_s2  <= off_c;
		sign_s2 <= sign_s1;
		ok_s2   <= ok_s1;

		days_s3 <= $signed(days_c);
		sod_s3  <= sod_s2;
		off_s3  <= off_s2;
		sign_s3 <= sign_s2;
		ok_s3   <= ok_s2;

		t_s4    <= day_secs + $signed(TimeW'(sod_s3));
		off_s4  <= off_s3;
		sign_s4 <= sign_s3;
		ok_s4   <= ok_s3;

		res.valid_res     <= good_c;
		res.epoch_seconds <= good_c ? secs_c[iutp_pkg::EPOCH_W-1:0] : '0;
	end

endmodule
`default_nettype wire

// File: hw/rtl/iso8601_utc_timestamp_parser.sv
// Top level of the ISO 8601 timestamp to Unix seconds parser.
// Throughput: one character per cycle while full is low, and at most one result per character.
// Path: a string's record goes through the record queue and the five conversion stages
// to the output queue; a record leaves the record queue only while the output queue has room.
// The output queue of OUT_DEPTH entries holds results while pop stays low.
// Reset: arst_n clears the parser state, both queues and the stage valids at once.
`timescale 1ns / 1ps
`default_nettype none
`include "iso8601_utc_timestamp_parser_macros.svh"
module iso8601_utc_timestamp_parser #(
	parameter int MID_DEPTH = iutp_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = iutp_pkg::OUT_DEPTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   push,
	output logic                                        full,
	input  wire logic [7:0]                             char_code,
	input  wire logic                                   last_char,
	output logic                                        empty,
	input  wire logic                                   pop,
	output logic                                        valid_res,
	output logic signed [iutp_pkg::EPOCH_W-1:0]         epoch_seconds
);

	logic                               accept;
	logic                               rec_push;
	iutp_pkg::record_t                  rec_in;
	iutp_pkg::record_t                  rec_out;
	logic                               mid_full;
	logic                               mid_empty;
	logic                               mid_pop;
	logic [$clog2(MID_DEPTH+1)-1:0]     mid_count;
	logic                               out_push;
	logic                               out_full;
	iutp_pkg::result_t                  res_in;
	iutp_pkg::result_t                  res_out;
	logic [$clog2(OUT_DEPTH+1)-1:0]     out_count;

	assign full   = mid_full;
	assign accept = push && !mid_full;

	iutp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.last_char (last_char),
		.rec_push  (rec_push),
		.rec       (rec_in)
	);

	iutp_queue #(
		.WIDTH ($bits(iutp_pkg::record_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (rec_out),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	iutp_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_empty (mid_empty),
		.rec       (rec_out),
		.rec_pop   (mid_pop),
		.out_count (out_count),
		.res_push  (out_push),
		.res       (res_in)
	);

	iutp_queue #(
		.WIDTH ($bits(iutp_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (res_in),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty),
		.count  (out_count)
	);

	assign valid_res     = res_out.valid_res;
	assign epoch_seconds = res_out.epoch_seconds;

	`IUTP_ASSERT_NEVER(a_out_no_overflow, out_push && out_full)
	`IUTP_ASSERT_NEVER(a_mid_count_bound, mid_count > MID_DEPTH)
	`IUTP_ASSERT(a_string_queued, (push && !full && last_char) |=> !mid_empty)
	`IUTP_ASSERT(a_invalid_zero, (!empty && !valid_res) |-> (epoch_seconds == '0))

endmodule
`default_nettype wire
